>>> rtl/core/spq_pkg.sv
// Shared types and constants for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Default number of job cells.
    localparam int QueueDepthDef = 16;

    // Field widths of one job.
    localparam int IdW   = 16;
    localparam int PageW = 16;
    localparam int PrioW = 8;
    localparam int OccW  = 5;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Operation codes on the input tuser.
    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_REMOVE = 1'b1
    } t_func;

    // Output register state of the controller.
    typedef enum logic {
        OUT_IDLE = 1'b0,
        OUT_HELD = 1'b1
    } t_out_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    do_insert;
        logic    do_remove;
        logic    load_result;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/spq_ctrl.sv
// Controller state machine: handshakes, output register state and datapath commands.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_func,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    t_out_state r_state;
    t_out_state n_state;
    logic       accept;

    // An item is taken whenever the result register is free or being emptied.
    assign o_in_ready = (r_state == OUT_IDLE) || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Next state of the result register.
    always_comb begin
        n_state = r_state;
        case (r_state)
            OUT_IDLE: begin
                if (accept) n_state = OUT_HELD;
            end
            OUT_HELD: begin
                if (accept) begin
                    n_state = OUT_HELD;
                end else if (i_out_ready) begin
                    n_state = OUT_IDLE;
                end
            end
            default: n_state = OUT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OUT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath and the result valid flag.
    always_comb begin
        o_out_valid       = (r_state == OUT_HELD);
        o_cmd.do_insert   = 1'b0;
        o_cmd.do_remove   = 1'b0;
        o_cmd.load_result = accept;
        o_cmd.status      = ST_INSERTED;
        case (t_func'(i_func))
            FN_INSERT: begin
                if (i_stat.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.status    = ST_INSERTED;
                    o_cmd.do_insert = accept;
                end
            end
            FN_REMOVE: begin
                if (i_stat.empty) begin
                    o_cmd.status = ST_EMPTY;
                end else begin
                    o_cmd.status    = ST_REMOVED;
                    o_cmd.do_remove = accept;
                end
            end
            default: o_cmd.status = ST_INSERTED;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/spq_datapath.sv
// Datapath: row of compare-and-shift job cells, fill count and result register.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [IdW-1:0]   i_job_id,
    input  wire logic [PageW-1:0] i_page_count,
    input  wire logic [PrioW-1:0] i_priority,
    output t_dp_stat              o_stat,
    output logic [1:0]            o_status,
    output logic [IdW-1:0]        o_job_id,
    output logic [PageW-1:0]      o_page_count,
    output logic [PrioW-1:0]      o_priority,
    output logic [OccW-1:0]       o_occupancy
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [IdW-1:0]   r_id   [QUEUE_DEPTH];
    logic [PageW-1:0] r_pg   [QUEUE_DEPTH];
    logic [PrioW-1:0] r_pr   [QUEUE_DEPTH];
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;
    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] take_new;
    logic [QUEUE_DEPTH-1:0] take_prev;

    logic [1:0]       r_status;
    logic [IdW-1:0]   r_out_id;
    logic [PageW-1:0] r_out_pg;
    logic [PrioW-1:0] r_out_pr;
    logic [OccW-1:0]  r_out_occ;

    assign o_stat.full  = (r_count == CntW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Each held cell whose priority is not above the new one stays in place.
    // Since the cells are sorted these flags form a prefix.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CntW'(i) < r_count) && (r_pr[i] <= i_priority);
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i == 0) begin
                take_new[i]  = !le[i];
                take_prev[i] = 1'b0;
            end else begin
                take_new[i]  = le[i-1] && !le[i];
                take_prev[i] = !le[i-1];
            end
        end
    end

    // Cell updates: open a gap on insert, shift toward the head on remove.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.do_insert) begin
                if (take_new[i]) begin
                    r_id[i] <= i_job_id;
                    r_pg[i] <= i_page_count;
                    r_pr[i] <= i_priority;
                end else if (take_prev[i]) begin
                    r_id[i] <= r_id[(i == 0) ? 0 : i - 1];
                    r_pg[i] <= r_pg[(i == 0) ? 0 : i - 1];
                    r_pr[i] <= r_pr[(i == 0) ? 0 : i - 1];
                end
            end else if (i_cmd.do_remove && (i < QUEUE_DEPTH - 1)) begin
                r_id[i] <= r_id[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_pg[i] <= r_pg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_pr[i] <= r_pr[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // Fill count.
    always_comb begin
        n_count = r_count;
        if (i_cmd.do_insert) begin
            n_count = r_count + CntW'(1);
        end else if (i_cmd.do_remove) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result register; job fields carry the head only on a remove.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_status  <= i_cmd.status;
            r_out_occ <= OccW'(n_count);
            if (i_cmd.do_remove) begin
                r_out_id <= r_id[0];
                r_out_pg <= r_pg[0];
                r_out_pr <= r_pr[0];
            end else begin
                r_out_id <= '0;
                r_out_pg <= '0;
                r_out_pr <= '0;
            end
        end
    end

    assign o_status     = r_status;
    assign o_job_id     = r_out_id;
    assign o_page_count = r_out_pg;
    assign o_priority   = r_out_pr;
    assign o_occupancy  = r_out_occ;

endmodule

`default_nettype wire

>>> rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of jobs held in a row of QUEUE_DEPTH compare-and-shift
// cells kept sorted by priority; smaller values leave first and equal values in
// arrival order. Each input item is one operation (insert or remove) and yields
// exactly one result item. The result of an accepted item is shown on the master
// side at the next clock edge, so one item per cycle is sustained while results
// are taken; the priority compare across all cells feeds the shift select of
// every cell. While a result waits untaken the input side is held off; it opens
// again in the cycle the result is taken. No clearing pass is needed after
// reset: the fill count marks which cells hold jobs.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: job_id [15:0], page_count [31:16], priority_req [39:32]
    input  wire logic [39:0] s_axis_tdata,
    // tuser: func [0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_job_id [15:0], out_page_count [31:16], out_priority [39:32],
    // occupancy [44:40], zero [47:45]
    output logic [47:0]      m_axis_tdata,
    // tuser: status [1:0]
    output logic [1:0]       m_axis_tuser
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [IdW-1:0]   out_id;
    logic [PageW-1:0] out_pg;
    logic [PrioW-1:0] out_pr;
    logic [OccW-1:0]  out_occ;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_func      (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_job_id     (s_axis_tdata[15:0]),
        .i_page_count (s_axis_tdata[31:16]),
        .i_priority   (s_axis_tdata[39:32]),
        .o_stat       (stat),
        .o_status     (m_axis_tuser),
        .o_job_id     (out_id),
        .o_page_count (out_pg),
        .o_priority   (out_pr),
        .o_occupancy  (out_occ)
    );

    assign m_axis_tdata = {3'b000, out_occ, out_pr, out_pg, out_id};

endmodule

`default_nettype wire

>>> rtl/core/spq_checker.sv
// Port-level assertions for the stable priority queue and their bind.
`timescale 1ns / 1ps
`default_nettype none

module spq_port_assertions
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef
)(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    localparam logic [OccW-1:0] FullOcc = OccW'(QUEUE_DEPTH);

    // Every accepted item shows its result at the next edge.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // A stalled result holds its contents.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // A rejected insert reports a full queue.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |-> (m_axis_tdata[44:40] == FullOcc))
        else $error("full status with wrong occupancy");

    // Only a remove carries job fields.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_REMOVED)) |-> (m_axis_tdata[39:0] == '0))
        else $error("job fields set on a result without a removed job");

    // An empty report leaves nothing held.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_EMPTY)) |-> (m_axis_tdata[44:40] == '0))
        else $error("empty status with nonzero occupancy");

endmodule

bind stable_priority_queue spq_port_assertions #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/spq_checker.sv
// Checker for the stable priority queue: predicts each result and compares the output stream.
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDef
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    // job_id [15:0], page_count [31:16], priority_req [39:32]
    input  wire logic [39:0] i_in_data,
    // func [0]
    input  wire logic        i_in_user,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    // out_job_id [15:0], out_page_count [31:16], out_priority [39:32],
    // occupancy [44:40], zero [47:45]
    input  wire logic [47:0] i_out_data,
    // status [1:0]
    input  wire logic [1:0]  i_out_user,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_inserted,
    output int               o_rejected,
    output int               o_removed,
    output int               o_empty_seen
);

    typedef struct {
        logic [IdW-1:0]   id;
        logic [PageW-1:0] pages;
        logic [PrioW-1:0] prio;
    } t_job_rec;

    typedef struct {
        t_status          status;
        logic [IdW-1:0]   id;
        logic [PageW-1:0] pages;
        logic [PrioW-1:0] prio;
        logic [OccW-1:0]  occ;
    } t_job_result;

    // Shadow copy of the sorted job list.
    t_job_rec    shadow_jobs [QUEUE_DEPTH];
    int          shadow_count;

    // Results still owed by the block, oldest first.
    t_job_result owed_results [$];

    int fails;
    int n_ins, n_full, n_rem, n_empty;

    initial begin
        fails        = 0;
        shadow_count = 0;
        n_ins        = 0;
        n_full       = 0;
        n_rem        = 0;
        n_empty      = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_inserted   = 0;
        o_rejected   = 0;
        o_removed    = 0;
        o_empty_seen = 0;
    end

    // Apply one insert or remove to the shadow list and queue the result it owes.
    task automatic apply_job_op(input t_func fn, input logic [IdW-1:0] id,
                                input logic [PageW-1:0] pages,
                                input logic [PrioW-1:0] prio);
        t_job_result r;
        int          pos;
        int          i;
        r.status = ST_INSERTED;
        r.id     = '0;
        r.pages  = '0;
        r.prio   = '0;
        if (fn == FN_INSERT) begin
            if (shadow_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // Stable placement: after every job with priority <= new one.
                pos = 0;
                while (pos < shadow_count && shadow_jobs[pos].prio <= prio)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_jobs[i] = shadow_jobs[i-1];
                shadow_jobs[pos].id    = id;
                shadow_jobs[pos].pages = pages;
                shadow_jobs[pos].prio  = prio;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.id    = shadow_jobs[0].id;
                r.pages = shadow_jobs[0].pages;
                r.prio  = shadow_jobs[0].prio;
                for (i = 1; i < shadow_count; i++)
                    shadow_jobs[i-1] = shadow_jobs[i];
                shadow_count--;
                r.status = ST_REMOVED;
            end
        end
        r.occ = OccW'(shadow_count);
        owed_results.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input int exp_val, input int act_val);
        $display("%0t ns: mismatch in %s: expected 0x%0h, actual 0x%0h",
                 $time, field, exp_val, act_val);
        fails++;
    endtask

    // Predict on each accepted input item, then check each accepted result.
    always @(posedge i_clk) begin
        t_job_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            owed_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                apply_job_op(t_func'(i_in_user), i_in_data[15:0], i_in_data[31:16],
                             i_in_data[39:32]);
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t ns: unexpected result, tuser 0x%0h tdata 0x%0h",
                             $time, i_out_user, i_out_data);
                    fails++;
                end else begin
                    want = owed_results.pop_front();
                    case (want.status)
                        ST_INSERTED: n_ins++;
                        ST_FULL:     n_full++;
                        ST_REMOVED:  n_rem++;
                        default:     n_empty++;
                    endcase
                    if (i_out_user !== want.status)
                        report_mismatch("status", want.status, i_out_user);
                    if (i_out_data[15:0] !== want.id)
                        report_mismatch("out_job_id", want.id, i_out_data[15:0]);
                    if (i_out_data[31:16] !== want.pages)
                        report_mismatch("out_page_count", want.pages, i_out_data[31:16]);
                    if (i_out_data[39:32] !== want.prio)
                        report_mismatch("out_priority", want.prio, i_out_data[39:32]);
                    if (i_out_data[44:40] !== want.occ)
                        report_mismatch("occupancy", want.occ, i_out_data[44:40]);
                    if (i_out_data[47:45] !== 3'b000)
                        report_mismatch("tdata padding", 0, i_out_data[47:45]);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_results.size();
        o_inserted   <= n_ins;
        o_rejected   <= n_full;
        o_removed    <= n_rem;
        o_empty_seen <= n_empty;
    end

endmodule

>>> tb/tb_stable_priority_queue.sv
// Testbench top for the stable priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_stable_priority_queue
    import spq_pkg::*;
();

    localparam int QUEUE_DEPTH  = QueueDepthDef;
    localparam int RANDOM_ITEMS = 450;
    localparam int MAX_GAP      = 18;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count, pending, n_ins, n_full, n_rem, n_empty;
    int cycles = 0;
    int rx_stall_left = 0;
    bit gaps_on = 1'b1;

    stable_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    spq_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_inserted   (n_ins),
        .o_rejected   (n_full),
        .o_removed    (n_rem),
        .o_empty_seen (n_empty)
    );

    // 8 ns clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("tb_stable_priority_queue: FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Priorities: mostly a tight band to force ties, plus full range and the extremes.
    function automatic logic [7:0] pick_priority();
        int sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0, 1:    return 8'($urandom_range(0, 3));
            2:       return 8'($urandom_range(0, 255));
            default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Result side: stall a random number of cycles before each item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = draw_gap();
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_stall_left = draw_gap();
            m_axis_tready <= (rx_stall_left == 0);
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= (rx_stall_left == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one operation after a random gap and hold it until it is accepted.
    task automatic send_item(input t_func fn, input logic [15:0] id,
                             input logic [15:0] pages, input logic [7:0] prio);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {prio, pages, id};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        int    k;
        int    items_left;
        int    phase_len;
        int    mode;
        int    insert_pct;
        t_func fn;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: remove from empty, fill with extremes and ties, overflow, partial drain.
        send_item(FN_REMOVE, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_item(FN_INSERT, 16'h0000, 16'h0000, 8'hFF);
        send_item(FN_INSERT, 16'hFFFF, 16'hFFFF, 8'h00);
        send_item(FN_INSERT, 16'h5A5A, 16'hA5A5, 8'hFF);
        for (k = 0; k < QUEUE_DEPTH - 3; k++)
            send_item(FN_INSERT, 16'(k + 1), ~16'(k), 8'((k % 3) * 100));
        send_item(FN_INSERT, 16'hBEEF, 16'h1234, 8'h00);
        for (k = 0; k < 7; k++)
            send_item(FN_REMOVE, 16'($urandom), 16'($urandom), 8'($urandom));

        // Random phases that lean toward filling, draining, or balance.
        items_left = RANDOM_ITEMS;
        while (items_left > 0) begin
            phase_len = $urandom_range(20, 60);
            mode      = $urandom_range(0, 2);
            gaps_on   = ($urandom_range(0, 4) != 0);
            insert_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            for (k = 0; k < phase_len && items_left > 0; k++) begin
                if ($urandom_range(0, 99) < insert_pct)
                    fn = FN_INSERT;
                else
                    fn = FN_REMOVE;
                send_item(fn, 16'($urandom), 16'($urandom), pick_priority());
                items_left--;
            end
        end
        s_axis_tvalid <= 1'b0;
        gaps_on = 1'b1;

        // Drain every outstanding result, then allow a few quiet cycles.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results: %0d inserts, %0d rejected as full, %0d removals,",
                 n_ins + n_full + n_rem + n_empty, n_ins, n_full, n_rem);
        $display("%0d removes from empty, under random stalls on both stream sides.", n_empty);
        if (fail_count == 0) begin
            $display("tb_stable_priority_queue: PASS");
        end else begin
            $display("tb_stable_priority_queue: FAIL");
        end
        $finish;
    end

endmodule
